/* design/jpeg_frame_size_scanner_top_macros.svh */
// assertion macros for the frame size scanner
`ifndef JPEG_FRAME_SIZE_SCANNER_TOP_MACROS_SVH
`define JPEG_FRAME_SIZE_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define JFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define JFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define JFS_ASSERT_SAME(label, clk, rst, ante, cons)
`define JFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/jfs_pkg.sv */
package jfs_pkg;

   typedef enum logic [3:0] {
      PH_START0  = 4'd0,
      PH_START1  = 4'd1,
      PH_HUNT_FF = 4'd2,
      PH_HUNT_CD = 4'd3,
      PH_LEN_HI  = 4'd4,
      PH_LEN_LO  = 4'd5,
      PH_SKIP    = 4'd6,
      PH_SOF     = 4'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_BADSTART = 3'd1,
      ST_SOS      = 3'd2,
      ST_EOI      = 3'd3,
      ST_EARLY    = 3'd4
   } status_type;

   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] CODE_SOI = 8'hD8;
   localparam logic [7:0] CODE_EOI = 8'hD9;
   localparam logic [7:0] CODE_SOS = 8'hDA;
   localparam logic [7:0] CODE_SOF = 8'hC0;
   localparam logic [7:0] CODE_DHT = 8'hC4;
   localparam logic [7:0] CODE_JPG = 8'hC8;
   localparam logic [7:0] CODE_DAC = 8'hCC;

   localparam logic [2:0] POS_HEIGHT_HI = 3'd3;
   localparam logic [2:0] POS_HEIGHT_LO = 3'd4;
   localparam logic [2:0] POS_WIDTH_HI  = 3'd5;

   function automatic logic is_sof(input logic [7:0] code);
      return (code[7:4] == CODE_SOF[7:4]) && (code != CODE_DHT) &&
             (code != CODE_JPG) && (code != CODE_DAC);
   endfunction

endpackage

/* design/jpeg_frame_size_scanner_top.sv */
// output: a result is registered and shows on rsp_valid in the cycle after the byte that completes it is taken
// throughput: one byte per cycle; the single result register stalls the input
// only while it holds an unaccepted transaction and rsp_stall is high
// reset: synchronous, active high; returns the parser to expect the first start byte
// and empties the result register
`include "jpeg_frame_size_scanner_top_macros.svh"

module jpeg_frame_size_scanner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_frame_width,
   output logic [15:0] rsp_frame_height
);
   import jfs_pkg::*;

   phase_type   parse_phase_ff, parse_phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  field_position_ff, field_position_in;
   logic [7:0]  high_byte_hold_ff, high_byte_hold_in;
   logic [15:0] height_hold_ff, height_hold_in;
   logic        result_given_ff, result_given_in;

   logic        rsp_valid_ff;
   status_type  rsp_status_ff;
   logic [15:0] rsp_width_ff;
   logic [15:0] rsp_height_ff;

   logic        accept;
   logic        res_valid;
   status_type  res_status;
   logic [15:0] res_width;
   logic [15:0] res_height;
   logic [15:0] seg_len;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign seg_len   = {high_byte_hold_ff, req_data_byte};

   always_comb begin
      parse_phase_in    = parse_phase_ff;
      bytes_left_in     = bytes_left_ff;
      field_position_in = field_position_ff;
      high_byte_hold_in = high_byte_hold_ff;
      height_hold_in    = height_hold_ff;
      result_given_in   = result_given_ff;
      res_valid         = 1'b0;
      res_status        = ST_FOUND;
      res_width         = 16'd0;
      res_height        = 16'd0;
      if (!result_given_ff) begin
         case (parse_phase_ff)
            PH_START0: begin
               high_byte_hold_in = req_data_byte;
               parse_phase_in    = PH_START1;
               if (req_last_byte) begin
                  res_valid  = 1'b1;
                  res_status = ST_BADSTART;
               end
            end
            PH_START1: begin
               if (high_byte_hold_ff != BYTE_FF || req_data_byte != CODE_SOI) begin
                  res_valid  = 1'b1;
                  res_status = ST_BADSTART;
               end else begin
                  parse_phase_in = PH_HUNT_FF;
               end
            end
            PH_HUNT_FF: begin
               if (req_data_byte == BYTE_FF) begin
                  parse_phase_in = PH_HUNT_CD;
               end
            end
            PH_HUNT_CD: begin
               if (req_data_byte == BYTE_FF) begin
                  parse_phase_in = PH_HUNT_CD;
               end else if (is_sof(req_data_byte)) begin
                  parse_phase_in    = PH_SOF;
                  field_position_in = 3'd0;
               end else if (req_data_byte == CODE_SOS) begin
                  res_valid  = 1'b1;
                  res_status = ST_SOS;
               end else if (req_data_byte == CODE_EOI) begin
                  res_valid  = 1'b1;
                  res_status = ST_EOI;
               end else begin
                  parse_phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               high_byte_hold_in = req_data_byte;
               parse_phase_in    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (seg_len <= 16'd2) begin
                  parse_phase_in = PH_HUNT_FF;
               end else begin
                  bytes_left_in  = seg_len - 16'd2;
                  parse_phase_in = PH_SKIP;
               end
            end
            PH_SKIP: begin
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) begin
                  parse_phase_in = PH_HUNT_FF;
               end
            end
            PH_SOF: begin
               case (field_position_ff)
                  3'd0, 3'd1, 3'd2: begin
                     high_byte_hold_in = high_byte_hold_ff;
                  end
                  POS_HEIGHT_HI, POS_WIDTH_HI: begin
                     high_byte_hold_in = req_data_byte;
                  end
                  POS_HEIGHT_LO: begin
                     height_hold_in = {high_byte_hold_ff, req_data_byte};
                  end
                  default: begin
                     res_valid  = 1'b1;
                     res_status = ST_FOUND;
                     res_width  = {high_byte_hold_ff, req_data_byte};
                     res_height = height_hold_ff;
                  end
               endcase
               field_position_in = field_position_ff + 3'd1;
            end
            default: begin
               parse_phase_in = PH_HUNT_FF;
            end
         endcase
         if (res_valid) begin
            result_given_in = 1'b1;
         end else if (req_last_byte) begin
            res_valid  = 1'b1;
            res_status = ST_EARLY;
         end
      end
      if (req_last_byte) begin
         parse_phase_in    = PH_START0;
         bytes_left_in     = 16'd0;
         field_position_in = 3'd0;
         high_byte_hold_in = 8'd0;
         height_hold_in    = 16'd0;
         result_given_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_phase_ff    <= PH_START0;
         bytes_left_ff     <= 16'd0;
         field_position_ff <= 3'd0;
         high_byte_hold_ff <= 8'd0;
         height_hold_ff    <= 16'd0;
         result_given_ff   <= 1'b0;
      end else if (accept) begin
         parse_phase_ff    <= parse_phase_in;
         bytes_left_ff     <= bytes_left_in;
         field_position_ff <= field_position_in;
         high_byte_hold_ff <= high_byte_hold_in;
         height_hold_ff    <= height_hold_in;
         result_given_ff   <= result_given_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_status_ff <= res_status;
         rsp_width_ff  <= res_width;
         rsp_height_ff <= res_height;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_width  = rsp_width_ff;
   assign rsp_frame_height = rsp_height_ff;

   `JFS_ASSERT_SAME(a_size_zero_unless_found, clock, reset, rsp_valid_ff && rsp_status_ff != ST_FOUND, rsp_width_ff == 16'd0 && rsp_height_ff == 16'd0)
   `JFS_ASSERT_NEXT(a_last_restarts_file, clock, reset, accept && req_last_byte, parse_phase_ff == PH_START0 && !result_given_ff)
   `JFS_ASSERT_NEXT(a_result_registered, clock, reset, accept && res_valid, rsp_valid_ff)
   `JFS_ASSERT_SAME(a_skip_count_nonzero, clock, reset, parse_phase_ff == PH_SKIP, bytes_left_ff != 16'd0)

endmodule
